// File: sv/rmfs_pkg.sv
`timescale 1ns / 1ps

package rmfs_pkg;

	localparam int LANES   = 4;
	localparam int LANE_IW = 2;   // lane select bits
	localparam int NV_W    = 3;   // lane count, 0..LANES
	localparam int MAX_DIM = 4096; // larger rows/cols are used as this
	localparam int DIM_W   = 13;
	localparam int ROW_W   = 13;
	localparam int COL_W   = 12;
	localparam int CNT_W   = 25;
	localparam int IDX_W   = 24;
	localparam int WORD_W  = 32;
	localparam int STEP_W  = 6;
	localparam int MOD_STEPS = 32;

	typedef enum logic [2:0] {
		REG_ROWS      = 3'd0,
		REG_COLS      = 3'd1,
		REG_TRANSPOSE = 3'd2,
		REG_CIRCULANT = 3'd3,
		REG_MODULUS   = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SETUP,
		ST_WAIT
	} rmfs_state_t;

	typedef struct packed {
		logic [DIM_W-1:0]  m;
		logic [DIM_W-1:0]  n;
		logic              transpose;
		logic              circulant;
		logic [WORD_W-1:0] modulus;
	} cfg_t;

	typedef struct packed {
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
		logic [WORD_W-1:0] word;
	} lane_req_t;

	typedef struct packed {
		logic [IDX_W-1:0]  index;
		logic [WORD_W-1:0] value;
	} lane_res_t;

	typedef struct packed {
		logic [IDX_W-1:0]  index;
		logic [WORD_W-1:0] value;
		logic              fill_done;
	} ent_t;

endpackage

// File: sv/rmfs_ifs.sv
`timescale 1ns / 1ps

interface rmfs_in_if;
	logic        valid;
	logic        ready;
	logic        restart_fill;
	logic [31:0] rand_word0;
	logic [31:0] rand_word1;
	logic [31:0] rand_word2;
	logic [31:0] rand_word3;

	modport source (output valid, output restart_fill, output rand_word0,
		output rand_word1, output rand_word2, output rand_word3, input ready);
	modport sink (input valid, input restart_fill, input rand_word0,
		input rand_word1, input rand_word2, input rand_word3, output ready);
endinterface

interface rmfs_out_if;
	logic        valid;
	logic        ready;
	logic [23:0] store_index;
	logic [31:0] store_value;
	logic        last_of_block;
	logic        fill_done;

	modport source (output valid, output store_index, output store_value,
		output last_of_block, output fill_done, input ready);
	modport sink (input valid, input store_index, input store_value,
		input last_of_block, input fill_done, output ready);
endinterface

// File: sv/random_matrix_fill_scatter_top.sv
`timescale 1ns / 1ps

// Random matrix fill scatter.
// in_ch carries one request per 128-bit random block: four 32-bit words and
// a restart_fill flag. Each word goes to the next element of an M x N matrix;
// out_ch gives one write request per element (store_index, store_value),
// last_of_block on the final write of a block, fill_done on the write that
// completes the matrix. A full matrix, or an empty one, gives no writes.
// Registers sit on the APB port at 4*i: rows, cols, transpose_mode,
// circulant_mode, modulus. Any register write restarts the fill at element 0.
// Timing: four lanes handle the four words side by side. A block goes from
// accept through setup to the lanes and then into the output queue; with a
// modulus each lane first runs the 32-step bit-serial remainder. Writes
// then leave one per cycle while out_ch.ready is high. The next block is
// accepted as soon as its predecessor has moved into the output queue, so
// the queue drains while the next block is in the lanes.
// Receiver stall: the output queue holds, and a finished block waits in the
// lanes until the queue is empty; in_ch.ready stays low meanwhile.
// Reset: rows = cols = 1, modes off, modulus 0, fill position at element 0.
module random_matrix_fill_scatter_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	rmfs_in_if.sink     in_ch,
	rmfs_out_if.source  out_ch
);

	localparam int L = rmfs_pkg::LANES;

	// configuration registers
	logic [12:0] rows_q;
	logic [12:0] cols_q;
	logic        trans_q;
	logic        circ_q;
	logic [31:0] modulus_q;
	logic        cfg_wr;
	logic        cfg_hit;
	rmfs_pkg::reg_idx_t cfg_idx;

	// fill position
	logic [rmfs_pkg::ROW_W-1:0] row_q;
	logic [rmfs_pkg::COL_W-1:0] col_q;
	logic [rmfs_pkg::CNT_W-1:0] ew_q;
	logic [rmfs_pkg::CNT_W-1:0] total_q;

	// captured block
	logic        restart_s1;
	logic [31:0] word_s1 [L];

	rmfs_pkg::rmfs_state_t state_q, state_d;
	rmfs_pkg::cfg_t        cfg;

	logic [rmfs_pkg::DIM_W-1:0]  m_dim, n_dim;
	logic [2*rmfs_pkg::DIM_W-1:0] total_prod;
	logic [rmfs_pkg::CNT_W-1:0]  ew_base;
	logic [rmfs_pkg::CNT_W-1:0]  remain;
	logic [rmfs_pkg::NV_W-1:0]   nvalid;
	logic [rmfs_pkg::NV_W-1:0]   nvalid_q;
	logic [rmfs_pkg::ROW_W-1:0]  pos_row [L+1];
	logic [rmfs_pkg::COL_W-1:0]  pos_col [L+1];
	logic [L-1:0]                fd;
	logic [L-1:0]                fd_q;

	logic                 in_acc;
	logic                 lane_start;
	logic                 mrg_load;
	logic                 mrg_empty;
	logic [L-1:0]         lane_done;
	rmfs_pkg::lane_req_t  lane_req [L];
	rmfs_pkg::lane_res_t  lane_res [L];
	rmfs_pkg::ent_t       mrg_ent  [L];

	// ---------------- APB register file ----------------
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = rmfs_pkg::reg_idx_t'(paddr[4:2]);

	always_comb begin
		case (cfg_idx)
			rmfs_pkg::REG_ROWS:      cfg_hit = 1'b1;
			rmfs_pkg::REG_COLS:      cfg_hit = 1'b1;
			rmfs_pkg::REG_TRANSPOSE: cfg_hit = 1'b1;
			rmfs_pkg::REG_CIRCULANT: cfg_hit = 1'b1;
			rmfs_pkg::REG_MODULUS:   cfg_hit = 1'b1;
			default:                 cfg_hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q    <= 13'd1;
			cols_q    <= 13'd1;
			trans_q   <= 1'b0;
			circ_q    <= 1'b0;
			modulus_q <= '0;
		end else if (cfg_wr) begin
			case (cfg_idx)
				rmfs_pkg::REG_ROWS:      rows_q    <= pwdata[12:0];
				rmfs_pkg::REG_COLS:      cols_q    <= pwdata[12:0];
				rmfs_pkg::REG_TRANSPOSE: trans_q   <= pwdata[0];
				rmfs_pkg::REG_CIRCULANT: circ_q    <= pwdata[0];
				rmfs_pkg::REG_MODULUS:   modulus_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			rmfs_pkg::REG_ROWS:      prdata = {19'd0, rows_q};
			rmfs_pkg::REG_COLS:      prdata = {19'd0, cols_q};
			rmfs_pkg::REG_TRANSPOSE: prdata = {31'd0, trans_q};
			rmfs_pkg::REG_CIRCULANT: prdata = {31'd0, circ_q};
			rmfs_pkg::REG_MODULUS:   prdata = modulus_q;
			default:                 prdata = '0;
		endcase
	end

	// oversized dimensions are used as MAX_DIM
	assign m_dim = ({19'd0, rows_q} > 32'(rmfs_pkg::MAX_DIM)) ?
		13'(rmfs_pkg::MAX_DIM) : rows_q;
	assign n_dim = ({19'd0, cols_q} > 32'(rmfs_pkg::MAX_DIM)) ?
		13'(rmfs_pkg::MAX_DIM) : cols_q;
	assign total_prod = (2*rmfs_pkg::DIM_W)'(m_dim) * (2*rmfs_pkg::DIM_W)'(n_dim);

	assign cfg.m         = m_dim;
	assign cfg.n         = n_dim;
	assign cfg.transpose = trans_q;
	assign cfg.circulant = circ_q;
	assign cfg.modulus   = modulus_q;

	// element count, registered; the user is bound to change config only while idle, the block leaves this to the user
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			total_q <= rmfs_pkg::CNT_W'(1);
		else
			total_q <= total_prod[rmfs_pkg::CNT_W-1:0];
	end

	// ---------------- block setup ----------------
	assign in_acc = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			restart_s1 <= in_ch.restart_fill;
			word_s1[0] <= in_ch.rand_word0;
			word_s1[1] <= in_ch.rand_word1;
			word_s1[2] <= in_ch.rand_word2;
			word_s1[3] <= in_ch.rand_word3;
		end
	end

	assign ew_base = restart_s1 ? '0 : ew_q;

	always_comb begin
		remain = total_q - ew_base;
		if (ew_base >= total_q)
			nvalid = '0;
		else if (remain >= rmfs_pkg::CNT_W'(L))
			nvalid = rmfs_pkg::NV_W'(L);
		else
			nvalid = remain[rmfs_pkg::NV_W-1:0];
	end

	// element position for each lane: walk one step per lane
	always_comb begin
		logic [rmfs_pkg::COL_W:0] col_inc;
		pos_row[0] = restart_s1 ? '0 : row_q;
		pos_col[0] = restart_s1 ? '0 : col_q;
		for (int i = 0; i < L; i++) begin
			col_inc = {1'b0, pos_col[i]} + 13'd1;
			if (col_inc >= n_dim) begin
				pos_col[i+1] = '0;
				pos_row[i+1] = pos_row[i] + rmfs_pkg::ROW_W'(1);
			end else begin
				pos_col[i+1] = col_inc[rmfs_pkg::COL_W-1:0];
				pos_row[i+1] = pos_row[i];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < L; i++) begin
			fd[i] = ((ew_base + rmfs_pkg::CNT_W'(i + 1)) == total_q);
			lane_req[i].row  = pos_row[i];
			lane_req[i].col  = pos_col[i];
			lane_req[i].word = word_s1[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
			ew_q  <= '0;
		end else if (cfg_wr && cfg_hit) begin
			row_q <= '0;
			col_q <= '0;
			ew_q  <= '0;
		end else if (state_q == rmfs_pkg::ST_SETUP) begin
			row_q <= pos_row[nvalid];
			col_q <= pos_col[nvalid];
			ew_q  <= ew_base + rmfs_pkg::CNT_W'(nvalid);
		end
	end

	always_ff @(posedge clk) begin
		if (lane_start) begin
			nvalid_q <= nvalid;
			fd_q     <= fd;
		end
	end

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= rmfs_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			rmfs_pkg::ST_IDLE:
				if (in_acc)
					state_d = rmfs_pkg::ST_SETUP;
			rmfs_pkg::ST_SETUP:
				state_d = (nvalid == '0) ? rmfs_pkg::ST_IDLE : rmfs_pkg::ST_WAIT;
			rmfs_pkg::ST_WAIT:
				if ((&lane_done) && mrg_empty)
					state_d = rmfs_pkg::ST_IDLE;
			default:
				state_d = rmfs_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ch.ready = 1'b0;
		lane_start  = 1'b0;
		mrg_load    = 1'b0;
		case (state_q)
			rmfs_pkg::ST_IDLE:  in_ch.ready = 1'b1;
			rmfs_pkg::ST_SETUP: lane_start  = (nvalid != '0);
			rmfs_pkg::ST_WAIT:  mrg_load    = (&lane_done) && mrg_empty;
			default: ;
		endcase
	end

	// ---------------- lanes ----------------
	for (genvar g = 0; g < L; g++) begin : g_lane
		rmfs_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.start  (lane_start),
			.ack    (mrg_load),
			.cfg    (cfg),
			.req    (lane_req[g]),
			.done   (lane_done[g]),
			.res    (lane_res[g])
		);
		assign mrg_ent[g].index     = lane_res[g].index;
		assign mrg_ent[g].value     = lane_res[g].value;
		assign mrg_ent[g].fill_done = fd_q[g];
	end

	// ---------------- merge / output queue ----------------
	rmfs_merge u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (mrg_load),
		.count  (nvalid_q),
		.ent    (mrg_ent),
		.empty  (mrg_empty),
		.out_ch (out_ch)
	);

	// ---------------- assertions ----------------
	a_load_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		mrg_load |-> mrg_empty && (&lane_done))
		else $error("output queue loaded while busy or lanes unfinished");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ew_q <= total_q || $past(cfg_wr && cfg_hit))
		else $error("elements written exceeds matrix size");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q == rmfs_pkg::ST_SETUP && !mrg_load)
		else $error("block accepted outside idle");

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		mrg_load |-> nvalid_q != '0 && nvalid_q <= rmfs_pkg::NV_W'(L))
		else $error("bad lane count at queue load");

endmodule

// File: sv/rmfs_lane.sv
`timescale 1ns / 1ps

module rmfs_lane (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                ack,
	input  rmfs_pkg::cfg_t      cfg,
	input  rmfs_pkg::lane_req_t req,
	output logic                done,
	output rmfs_pkg::lane_res_t res
);

	logic                          busy_q;
	logic [rmfs_pkg::STEP_W-1:0]   cnt_q;
	logic [rmfs_pkg::ROW_W-1:0]    row_q;
	logic [rmfs_pkg::COL_W-1:0]    col_q;
	logic [rmfs_pkg::WORD_W-1:0]   div_q;
	logic [rmfs_pkg::WORD_W-1:0]   rem_q;
	logic [2*rmfs_pkg::DIM_W-1:0]  prod_q;

	logic [rmfs_pkg::COL_W-1:0]    cc;
	logic [rmfs_pkg::DIM_W-1:0]    mul_a;
	logic [rmfs_pkg::DIM_W-1:0]    mul_b;
	logic [rmfs_pkg::DIM_W-1:0]    addend;
	logic [2*rmfs_pkg::DIM_W-1:0]  idx_sum;
	logic [rmfs_pkg::WORD_W:0]     trial;
	logic                          stepping;

	assign stepping = busy_q && (cnt_q != '0);

	// circulant column: (N - c) mod N
	always_comb begin
		cc = col_q;
		if (cfg.circulant && (col_q != '0))
			cc = rmfs_pkg::COL_W'(cfg.n - {1'b0, col_q});
	end

	always_comb begin
		if (cfg.transpose) begin
			mul_a  = {1'b0, cc};
			mul_b  = cfg.m;
			addend = row_q;
		end else begin
			mul_a  = row_q;
			mul_b  = cfg.n;
			addend = {1'b0, cc};
		end
	end

	// restoring remainder step, one dividend bit per cycle
	assign trial = {rem_q, div_q[rmfs_pkg::WORD_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= (cfg.modulus == '0) ? rmfs_pkg::STEP_W'(1)
				: rmfs_pkg::STEP_W'(rmfs_pkg::MOD_STEPS);
		end else if (ack) begin
			busy_q <= 1'b0;
		end else if (stepping) begin
			cnt_q <= cnt_q - rmfs_pkg::STEP_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= (2*rmfs_pkg::DIM_W)'(mul_a) * (2*rmfs_pkg::DIM_W)'(mul_b);
		if (start) begin
			row_q <= req.row;
			col_q <= req.col;
			div_q <= req.word;
			rem_q <= '0;
		end else if (stepping && (cfg.modulus != '0)) begin
			div_q <= {div_q[rmfs_pkg::WORD_W-2:0], 1'b0};
			if (trial >= {1'b0, cfg.modulus})
				rem_q <= rmfs_pkg::WORD_W'(trial - {1'b0, cfg.modulus});
			else
				rem_q <= trial[rmfs_pkg::WORD_W-1:0];
		end
	end

	assign idx_sum   = prod_q + {{rmfs_pkg::DIM_W{1'b0}}, addend};
	assign done      = busy_q && (cnt_q == '0);
	assign res.index = idx_sum[rmfs_pkg::IDX_W-1:0];
	assign res.value = (cfg.modulus == '0) ? div_q : rem_q;

endmodule

// File: sv/rmfs_merge.sv
`timescale 1ns / 1ps

module rmfs_merge (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       load,
	input  logic [rmfs_pkg::NV_W-1:0]  count,
	input  rmfs_pkg::ent_t             ent [rmfs_pkg::LANES],
	output logic                       empty,
	rmfs_out_if.source                 out_ch
);

	rmfs_pkg::ent_t                ent_q [rmfs_pkg::LANES];
	logic [rmfs_pkg::NV_W-1:0]     cnt_q;
	logic [rmfs_pkg::NV_W-1:0]     rd_q;
	rmfs_pkg::ent_t                head;

	assign empty = (rd_q == cnt_q);
	assign head  = ent_q[rd_q[rmfs_pkg::LANE_IW-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_q  <= '0;
		end else if (load) begin
			cnt_q <= count;
			rd_q  <= '0;
		end else if (out_ch.valid && out_ch.ready) begin
			rd_q <= rd_q + rmfs_pkg::NV_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			ent_q <= ent;
	end

	assign out_ch.valid         = !empty;
	assign out_ch.store_index   = head.index;
	assign out_ch.store_value   = head.value;
	assign out_ch.fill_done     = head.fill_done;
	assign out_ch.last_of_block = ((rd_q + rmfs_pkg::NV_W'(1)) == cnt_q);

endmodule

// File: sim/random_matrix_fill_scatter_top_tb.sv
`timescale 1ns / 1ps

module random_matrix_fill_scatter_top_tb;

	localparam int MAX_DIM       = rmfs_pkg::MAX_DIM;
	// the modulus path is the slowest per block; leave margin for a block that
	// writes nothing and is still in setup when the last write left
	localparam int SETTLE_CYCLES = 60;
	localparam int TAIL_CYCLES   = 60;
	// holes in the register map, a write there must not touch the fill
	localparam logic [2:0] REG_SPARE_LO = 3'd5;
	localparam logic [2:0] REG_SPARE_HI = 3'd7;

	typedef struct packed {
		logic [rmfs_pkg::IDX_W-1:0]  index;
		logic [rmfs_pkg::WORD_W-1:0] value;
		logic              last;
		logic              done;
	} store_write_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	rmfs_in_if  in_ch();
	rmfs_out_if out_ch();

	random_matrix_fill_scatter_top uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.in_ch   (in_ch),
		.out_ch  (out_ch)
	);

	// scatter predictor: register copy and fill position
	logic [12:0] cfg_rows;
	logic [12:0] cfg_cols;
	logic        cfg_transpose;
	logic        cfg_circulant;
	logic [31:0] cfg_modulus;
	int unsigned fill_row;
	int unsigned fill_col;
	longint unsigned fill_count;

	store_write_t expected_writes[$];
	int mismatch_count = 0;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// write side backpressure, redrawn every cycle
	always @(negedge clk) begin
		out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic report_mismatch(input string field, input logic [31:0] got,
		input logic [31:0] want);
		$display("%0t: %s mismatch: got 0x%0h, expected 0x%0h", $time, field, got, want);
		mismatch_count++;
	endtask

	// each accepted write is matched against the oldest predicted write
	always @(posedge clk) begin : check_writes
		store_write_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_writes.size() == 0) begin
				report_mismatch("unexpected write, index", 32'(out_ch.store_index), '0);
			end else begin
				want = expected_writes.pop_front();
				if (out_ch.store_index !== want.index)
					report_mismatch("store_index", 32'(out_ch.store_index),
						32'(want.index));
				if (out_ch.store_value !== want.value)
					report_mismatch("store_value", out_ch.store_value, want.value);
				if (out_ch.last_of_block !== want.last)
					report_mismatch("last_of_block", 32'(out_ch.last_of_block),
						32'(want.last));
				if (out_ch.fill_done !== want.done)
					report_mismatch("fill_done", 32'(out_ch.fill_done), 32'(want.done));
			end
		end
	end

	// M*N after clamping each dimension to MAX_DIM
	function automatic longint unsigned fill_total();
		longint unsigned m;
		longint unsigned n;
		m = (cfg_rows > 13'(MAX_DIM)) ? 64'(MAX_DIM) : 64'(cfg_rows);
		n = (cfg_cols > 13'(MAX_DIM)) ? 64'(MAX_DIM) : 64'(cfg_cols);
		return m * n;
	endfunction

	// Place the four words of one block into the matrix, queue the writes,
	// return how many writes the block causes.
	function automatic int predict_scatter(input logic restart,
		input logic [3:0][31:0] words);
		longint unsigned m;
		longint unsigned n;
		longint unsigned total;
		longint unsigned cc;
		longint unsigned idx;
		logic [31:0]     v;
		store_write_t    wr;
		int              cnt;
		m = (cfg_rows > 13'(MAX_DIM)) ? 64'(MAX_DIM) : 64'(cfg_rows);
		n = (cfg_cols > 13'(MAX_DIM)) ? 64'(MAX_DIM) : 64'(cfg_cols);
		total = m * n;
		cnt = 0;
		if (restart) begin
			fill_row = 0;
			fill_col = 0;
			fill_count = 0;
		end
		for (int i = 0; i < 4; i++) begin
			if (fill_count >= total)
				break;
			v = words[i];
			if (cfg_modulus != 0)
				v = v % cfg_modulus;
			cc = 64'(fill_col);
			if (cfg_circulant && cc != 0)
				cc = n - cc;
			idx = cfg_transpose ? cc * m + 64'(fill_row) : 64'(fill_row) * n + cc;
			fill_count++;
			fill_col++;
			if (64'(fill_col) >= n) begin
				fill_col = 0;
				fill_row++;
			end
			wr.index = idx[rmfs_pkg::IDX_W-1:0];
			wr.value = v;
			wr.done  = (fill_count == total);
			// final write of the block: fourth word, or the matrix ran out
			wr.last  = (i == 3) || wr.done;
			expected_writes.push_back(wr);
			cnt++;
		end
		return cnt;
	endfunction

	// drop valid at the next falling edge; the last request must not repeat
	task automatic hold_input();
		@(negedge clk);
		in_ch.valid <= 1'b0;
	endtask

	task automatic drain_writes();
		hold_input();
		while (expected_writes.size() != 0)
			@(posedge clk);
	endtask

	// block idle: no write pending, and any writeless block out of setup
	task automatic quiesce();
		drain_writes();
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// APB write: setup, then access; register loads on the access edge
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			rmfs_pkg::REG_ROWS:      cfg_rows      = value[12:0];
			rmfs_pkg::REG_COLS:      cfg_cols      = value[12:0];
			rmfs_pkg::REG_TRANSPOSE: cfg_transpose = value[0];
			rmfs_pkg::REG_CIRCULANT: cfg_circulant = value[0];
			rmfs_pkg::REG_MODULUS:   cfg_modulus   = value;
			default:       ;
		endcase
		// any known register aborts the fill
		if (idx inside {rmfs_pkg::REG_ROWS, rmfs_pkg::REG_COLS, rmfs_pkg::REG_TRANSPOSE,
			rmfs_pkg::REG_CIRCULANT, rmfs_pkg::REG_MODULUS}) begin
			fill_row = 0;
			fill_col = 0;
			fill_count = 0;
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic apply_settings(input logic [12:0] rows, input logic [12:0] cols,
		input logic transpose, input logic circulant, input logic [31:0] modulus);
		quiesce();
		write_reg(rmfs_pkg::REG_ROWS, 32'(rows));
		write_reg(rmfs_pkg::REG_COLS, 32'(cols));
		write_reg(rmfs_pkg::REG_TRANSPOSE, 32'(transpose));
		write_reg(rmfs_pkg::REG_CIRCULANT, 32'(circulant));
		write_reg(rmfs_pkg::REG_MODULUS, modulus);
	endtask

	// One block request. Valid stays high after acceptance so blocks can go
	// back to back; the next call replaces or lowers it, hold_input() lowers it.
	task automatic send_block(input logic restart, input logic [31:0] w0,
		input logic [31:0] w1, input logic [31:0] w2, input logic [31:0] w3,
		output int n_writes);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			in_ch.valid <= 1'b0;
		end
		@(negedge clk);
		in_ch.valid        <= 1'b1;
		in_ch.restart_fill <= restart;
		in_ch.rand_word0   <= w0;
		in_ch.rand_word1   <= w1;
		in_ch.rand_word2   <= w2;
		in_ch.rand_word3   <= w3;
		do @(posedge clk); while (!in_ch.ready);
		n_writes = predict_scatter(restart, {w3, w2, w1, w0});
	endtask

	// reset dims are 1x1: one write, then nothing until a restart
	task automatic test_reset_state();
		int n;
		send_block(1'b0, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, n);
		send_block(1'b0, 32'h1234_5678, 32'h0, 32'h0, 32'h0, n);
		send_block(1'b1, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0, n);
	endtask

	task automatic test_dimension_cases();
		int n;
		// 3x5: three full blocks, then a partial final block, then nothing
		apply_settings(13'd3, 13'd5, 1'b0, 1'b0, 32'd0);
		send_block(1'b0, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, n);
		repeat (3)
			send_block(1'b0, $urandom(), $urandom(), $urandom(), $urandom(), n);
		send_block(1'b0, $urandom(), $urandom(), $urandom(), $urandom(), n);
		// transposed, circulant, small modulus
		apply_settings(13'd3, 13'd5, 1'b1, 1'b1, 32'd7);
		repeat (4)
			send_block(1'b0, $urandom(), $urandom(), $urandom(), $urandom(), n);
		// empty matrix either way
		apply_settings(13'd0, 13'd5, 1'b0, 1'b0, 32'd0);
		send_block(1'b0, $urandom(), $urandom(), $urandom(), $urandom(), n);
		apply_settings(13'd4, 13'd0, 1'b0, 1'b0, 32'd0);
		send_block(1'b1, $urandom(), $urandom(), $urandom(), $urandom(), n);
		// oversize dims clamp to MAX_DIM; top index corner; widest modulus
		apply_settings(13'h1FFF, 13'h1FFF, 1'b1, 1'b1, 32'hFFFF_FFFF);
		send_block(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h0, 32'hFFFF_FFFF, n);
		send_block(1'b0, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'h8000_0000, 32'h1, n);
		// modulus 1 zeroes every value
		apply_settings(13'd2, 13'd3, 1'b0, 1'b0, 32'd1);
		send_block(1'b0, $urandom(), 32'hFFFF_FFFF, $urandom(), $urandom(), n);
	endtask

	task automatic test_fill_abort();
		int n;
		apply_settings(13'd2, 13'd4, 1'b0, 1'b1, 32'd0);
		send_block(1'b0, $urandom(), $urandom(), $urandom(), $urandom(), n);
		// unmapped register: fill carries on to completion
		quiesce();
		write_reg(REG_SPARE_LO, $urandom());
		send_block(1'b0, $urandom(), $urandom(), $urandom(), $urandom(), n);
		send_block(1'b1, $urandom(), $urandom(), $urandom(), $urandom(), n);
		// restart in the middle of a fill
		send_block(1'b1, $urandom(), $urandom(), $urandom(), $urandom(), n);
		// register write mid-fill starts over at element zero
		quiesce();
		write_reg(rmfs_pkg::REG_MODULUS, 32'd5);
		write_reg(REG_SPARE_HI, $urandom());
		send_block(1'b0, $urandom(), $urandom(), $urandom(), $urandom(), n);
	endtask

	// mostly small dims so fills complete often; sometimes empty or oversize
	function automatic logic [12:0] pick_dim();
		int sel;
		sel = $urandom_range(99);
		if (sel < 80)      return 13'($urandom_range(1, 6));
		else if (sel < 86) return 13'($urandom_range(7, 40));
		else if (sel < 90) return 13'd0;
		else if (sel < 95) return 13'($urandom_range(4096, 8191));
		else               return 13'($urandom_range(0, 8191));
	endfunction

	task automatic run_random_phase(input int send_pct, input int stall_pct,
		input int target);
		int          sent;
		int          sel;
		int          n;
		logic [31:0] modulus;
		logic        restart;
		send_idle_pct  = send_pct;
		recv_stall_pct = stall_pct;
		sent = 0;
		while (sent < target) begin
			sel = $urandom_range(99);
			if (sel < 40)      modulus = 32'd0;
			else if (sel < 70) modulus = $urandom_range(2, 16);
			else if (sel < 78) modulus = 32'd1;
			else if (sel < 92) modulus = $urandom();
			else               modulus = 32'hFFFF_FFFF;
			apply_settings(pick_dim(), pick_dim(), 1'($urandom_range(1)),
				1'($urandom_range(1)), modulus);
			if ($urandom_range(7) == 0)
				write_reg($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI, $urandom());
			repeat ($urandom_range(4, 24)) begin
				// restart now and then, and usually once the matrix is full
				restart = ($urandom_range(99) < 6) ||
					(fill_count >= fill_total() && $urandom_range(99) < 70);
				// hold off until every pending write is out
				if ($urandom_range(39) == 0)
					drain_writes();
				send_block(restart, $urandom(), $urandom(), $urandom(), $urandom(), n);
				sent++;
			end
		end
	endtask

	initial begin
		arst_n             = 1'b0;
		psel               = 1'b0;
		penable            = 1'b0;
		pwrite             = 1'b0;
		paddr              = '0;
		pwdata             = '0;
		in_ch.valid        = 1'b0;
		in_ch.restart_fill = 1'b0;
		in_ch.rand_word0   = '0;
		in_ch.rand_word1   = '0;
		in_ch.rand_word2   = '0;
		in_ch.rand_word3   = '0;
		out_ch.ready       = 1'b0;
		cfg_rows      = 13'd1;
		cfg_cols      = 13'd1;
		cfg_transpose = 1'b0;
		cfg_circulant = 1'b0;
		cfg_modulus   = 32'd0;
		fill_row   = 0;
		fill_col   = 0;
		fill_count = 0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		send_idle_pct  = 27;
		recv_stall_pct = 73;
		test_reset_state();
		test_dimension_cases();
		test_fill_abort();
		run_random_phase(27, 73, 136);
		run_random_phase(73, 27, 136);
		run_random_phase(0, 0, 136);

		// let stray writes surface after the last expected one
		drain_writes();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_writes.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// hang guard, many times the slowest legal run
	initial begin
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

// File: files.f
sv/rmfs_pkg.sv
sv/rmfs_ifs.sv
sv/rmfs_lane.sv
sv/rmfs_merge.sv
sv/random_matrix_fill_scatter_top.sv
sim/random_matrix_fill_scatter_top_tb.sv
